/* sv/dbrq_pkg.sv */
// shared types, constants and codes for the dedup bounded request queue
package dbrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic [1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [1:0] MODE_REMOVE  = 2'd2;
    localparam logic [1:0] MODE_LOOKUP  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] entry_key;
        logic [63:0] entry_payload;
    } req_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      out_key;
        logic [63:0]      out_payload;
        logic [OCC_W-1:0] occupancy;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic exec;
    } dbrq_cmd_t;

endpackage

/* sv/dbrq_ctrl.sv */
// controller state machine: request intake, compare and execute sequencing
module dbrq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dbrq_pkg::dbrq_cmd_t cmd
);
    import dbrq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    // result register can take a new value
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) || ((state_reg == S_EXEC) && out_free));
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.load    = req_valid && !req_stall;
        cmd.compare = (state_reg == S_MATCH);
        cmd.exec    = (state_reg == S_EXEC) && out_free;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_MATCH;
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = req_valid ? S_MATCH : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.exec)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* sv/dbrq_datapath.sv */
// datapath: entry store, parallel key compare, compaction and result register
module dbrq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dbrq_pkg::dbrq_cmd_t cmd,
    input  dbrq_pkg::req_item_t req,
    output dbrq_pkg::rsp_item_t rsp
);
    import dbrq_pkg::*;

    req_item_t              req_reg;
    logic [31:0]            key_store  [QUEUE_DEPTH];
    logic [63:0]            pay_store  [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [QUEUE_DEPTH-1:0] ge_vec;
    logic [QUEUE_DEPTH-1:0] ge_reg;
    logic [QUEUE_DEPTH-1:0] shift_mask;
    logic                   found;
    logic                   full;
    logic                   empty;
    logic                   do_write;
    logic                   do_shift;
    rsp_item_t              rsp_reg;
    rsp_item_t              rsp_next;

    // key compare against every live slot
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            hit_vec[i] = (CNT_W'(i) < count_reg) && (key_store[i] == req_reg.entry_key);
    end

    // slots at or above the oldest match
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_ge
            assign ge_vec[g] = |hit_vec[g:0];
        end
    endgenerate

    assign found = ge_reg[QUEUE_DEPTH-1];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        rsp_next             = '0;
        do_write             = 1'b0;
        do_shift             = 1'b0;
        shift_mask           = ge_reg;
        count_next           = count_reg;
        case (req_reg.mode)
            MODE_ENQUEUE:
            begin
                if (full)
                    rsp_next.status = ST_FULL;
                else if (found)
                    rsp_next.status = ST_DUP;
                else
                begin
                    do_write   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_DEQUEUE:
            begin
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else
                begin
                    rsp_next.out_key     = key_store[0];
                    rsp_next.out_payload = pay_store[0];
                    do_shift             = 1'b1;
                    shift_mask           = '1;
                    count_next           = count_reg - CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (found)
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                    rsp_next.status = ST_NOTFOUND;
            end
            MODE_LOOKUP:
            begin
                if (!found)
                    rsp_next.status = ST_NOTFOUND;
            end
            default:
            begin
                rsp_next.status = ST_NOTFOUND;
            end
        endcase
        rsp_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.compare)
            ge_reg <= ge_vec;
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (do_shift && shift_mask[i])
                begin
                    key_store[i] <= key_store[i+1];
                    pay_store[i] <= pay_store[i+1];
                end
            end
            if (do_write)
            begin
                key_store[count_reg[IDX_W-1:0]] <= req_reg.entry_key;
                pay_store[count_reg[IDX_W-1:0]] <= req_reg.entry_payload;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    assign rsp = rsp_reg;

endmodule

/* sv/dedup_bounded_request_queue.sv */
// top level of the dedup bounded request queue
// Holds up to 16 keyed requests in arrival order. Each request transfer on the
// req channel carries a mode (enqueue, dequeue oldest, remove by key, lookup),
// a 32-bit key and a 64-bit payload. Enqueue is refused when full or when the
// key is already queued; remove deletes the oldest match and keeps the order.
// Exactly one rsp transfer follows each req transfer, in order, with a status,
// the dequeued key and payload (zero otherwise) and the occupancy afterwards.
// After the req transfer the request is registered, then the parallel key
// compare over all slots is registered, then the update and the result
// register follow once the result register is free. A new request is taken
// in the cycle its predecessor's result is loaded; the compare and update
// steps work on one request at a time.
// When rsp_stall is high the result holds in its register; one further
// request may be taken and compared, then req_stall rises until the result
// transfers. Reset empties the queue and drops any pending result; stored
// entries are not cleared and are never read before being written.
module dedup_bounded_request_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  dbrq_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output dbrq_pkg::rsp_item_t rsp
);
    import dbrq_pkg::*;

    dbrq_cmd_t cmd;

    dbrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    dbrq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the dedup bounded request queue
`timescale 1ns / 100ps

module tb_top;
    import dbrq_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    // keeps its own copy of the queue and the results it should produce
    class queue_scoreboard;
        logic [31:0] keys [QUEUE_DEPTH];
        logic [63:0] payloads [QUEUE_DEPTH];
        int unsigned count;
        int unsigned mismatches;
        rsp_item_t   outcomes [$];

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return outcomes.size();
        endfunction

        // oldest slot holding the key, or count when absent
        function int unsigned slot_of(logic [31:0] key);
            for (int unsigned i = 0; i < count; i++)
            begin
                if (keys[i] == key)
                    return i;
            end
            return count;
        endfunction

        function void close_gap(int unsigned pos);
            for (int unsigned i = pos; i + 1 < count; i++)
            begin
                keys[i]     = keys[i + 1];
                payloads[i] = payloads[i + 1];
            end
            count--;
        endfunction

        function void note_request(req_item_t r);
            rsp_item_t   o;
            int unsigned pos;
            o        = '0;
            o.status = ST_OK;
            case (r.mode)
                MODE_ENQUEUE:
                begin
                    // fullness wins over the duplicate test
                    if (count >= QUEUE_DEPTH)
                        o.status = ST_FULL;
                    else if (slot_of(r.entry_key) < count)
                        o.status = ST_DUP;
                    else
                    begin
                        keys[count]     = r.entry_key;
                        payloads[count] = r.entry_payload;
                        count++;
                    end
                end
                MODE_DEQUEUE:
                begin
                    if (count == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        o.out_key     = keys[0];
                        o.out_payload = payloads[0];
                        close_gap(0);
                    end
                end
                MODE_REMOVE:
                begin
                    pos = slot_of(r.entry_key);
                    if (pos < count)
                        close_gap(pos);
                    else
                        o.status = ST_NOTFOUND;
                end
                default:
                begin
                    if (slot_of(r.entry_key) >= count)
                        o.status = ST_NOTFOUND;
                end
            endcase
            o.occupancy = OCC_W'(count);
            outcomes.push_back(o);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (outcomes.size() == 0)
            begin
                $error("response transfer with nothing outstanding: %p", got);
                mismatches++;
                return;
            end
            want = outcomes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.out_key !== want.out_key)
            begin
                $error("out_key: expected %h, got %h", want.out_key, got.out_key);
                mismatches++;
            end
            if (got.out_payload !== want.out_payload)
            begin
                $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    queue_scoreboard board;
    logic [31:0]     key_pool [POOL_SIZE];
    int              idle_pct  = 35;
    int              stall_pct = 35;
    int              quiet_cycles = 0;

    dedup_bounded_request_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_item_t make_request(logic [1:0] mode, logic [31:0] key,
                                               logic [63:0] payload);
        req_item_t r;
        r.mode          = mode;
        r.entry_key     = key;
        r.entry_payload = payload;
        return r;
    endfunction

    // mostly keys that are queued or from a small pool, so hits and duplicates are common
    function automatic req_item_t random_request(int enq_weight);
        req_item_t r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < enq_weight)
            r.mode = MODE_ENQUEUE;
        else if (pick < enq_weight + (100 - enq_weight) / 2)
            r.mode = MODE_DEQUEUE;
        else if ($urandom_range(1) == 1)
            r.mode = MODE_REMOVE;
        else
            r.mode = MODE_LOOKUP;
        pick = $urandom_range(99);
        if (board.count != 0 && pick < 45)
            r.entry_key = board.keys[$urandom_range(board.count - 1)];
        else if (pick < 90)
            r.entry_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            r.entry_key = $urandom;
        r.entry_payload = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_request(input req_item_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(item);
    endtask

    // hold the request side until every outstanding result has transferred
    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // result side with random stalls
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= ($urandom_range(99) < stall_pct);
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_response(rsp);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL dedup_bounded_request_queue");
            $finish;
        end
    end

    initial
    begin
        int n;
        board     = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue cases
        send_request(make_request(MODE_DEQUEUE, 32'h0, 64'h0));
        send_request(make_request(MODE_REMOVE, 32'hFFFF_FFFF, '1));
        send_request(make_request(MODE_LOOKUP, 32'h0, 64'h0));
        // extreme keys and payloads, duplicate, hit, removal of the oldest
        send_request(make_request(MODE_ENQUEUE, 32'h0, 64'h0));
        send_request(make_request(MODE_ENQUEUE, 32'hFFFF_FFFF, '1));
        send_request(make_request(MODE_ENQUEUE, 32'h0, 64'h5555_5555_5555_5555));
        send_request(make_request(MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0));
        send_request(make_request(MODE_REMOVE, 32'h0, 64'h0));
        n = 2;
        while (board.count < QUEUE_DEPTH)
        begin
            send_request(make_request(MODE_ENQUEUE, key_pool[n], {$urandom, $urandom}));
            n++;
        end
        // full queue and queued key: full is reported
        send_request(make_request(MODE_ENQUEUE, 32'hFFFF_FFFF, 64'h0));
        send_request(make_request(MODE_REMOVE, key_pool[8], 64'h0));
        send_request(make_request(MODE_DEQUEUE, 32'h0, 64'h0));
        send_request(make_request(MODE_LOOKUP, key_pool[8], 64'h0));
        wait_for_drain();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= 250 && n < 370)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = 35;
                stall_pct = 35;
            end
            if (n % 150 == 149)
                wait_for_drain();
            // alternate between filling and draining so both ends are reached
            send_request(random_request(((n / 60) % 2 == 0) ? 70 : 25));
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("PASS dedup_bounded_request_queue");
        else
            $display("FAIL dedup_bounded_request_queue");
        $finish;
    end

endmodule

/* files.f */
sv/dbrq_pkg.sv
sv/dbrq_ctrl.sv
sv/dbrq_datapath.sv
sv/dedup_bounded_request_queue.sv
tb/tb_top.sv
